// ===== hw/rtl/i2crm_pkg.sv =====
package i2crm_pkg;

   localparam int unsigned CsrIndexWidth = 1;
   localparam int unsigned CsrDataWidth  = 8;

   // Configuration register indexes.
   localparam logic [CsrIndexWidth-1:0] CSR_PHASE_TICKS = 1'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_ACK_TIMEOUT = 1'd1;

   localparam logic [7:0] PHASE_TICKS_RESET = 8'd1;
   localparam logic [7:0] ACK_TIMEOUT_RESET = 8'd250;

   // Completion status codes.
   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_BUS_BUSY = 2'd1;
   localparam logic [1:0] STATUS_NO_ACK   = 2'd2;

   typedef struct packed {
      logic [7:0] phase_ticks;
      logic [7:0] ack_timeout;
   } cfg_type;

   typedef struct packed {
      logic       sda_in;
      logic       cmd_valid;
      logic       cmd_read;
      logic [6:0] dev_addr;
      logic [7:0] reg_addr;
      logic [7:0] byte_count;
      logic [7:0] wr_data;
      logic       wr_data_valid;
   } req_type;

   typedef struct packed {
      logic       scl_out;
      logic       sda_out;
      logic       sda_oe;
      logic [7:0] rd_data;
      logic       rd_valid;
      logic       rd_last;
      logic       wr_data_request;
      logic       busy_res;
      logic       done_res;
      logic [1:0] status;
   } rsp_type;

endpackage

// ===== hw/rtl/i2crm_csr.sv =====
module i2crm_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [i2crm_pkg::CsrIndexWidth-1:0]  csr_index,
   input  logic [i2crm_pkg::CsrDataWidth-1:0]   csr_data,
   output i2crm_pkg::cfg_type                   cfg
);
   import i2crm_pkg::*;

   logic [7:0] phase_ticks_ff, phase_ticks_in;
   logic [7:0] ack_timeout_ff, ack_timeout_in;

   assign csr_ready = 1'b1;

   always_comb begin
      phase_ticks_in = phase_ticks_ff;
      ack_timeout_in = ack_timeout_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_PHASE_TICKS: phase_ticks_in = csr_data;
            CSR_ACK_TIMEOUT: ack_timeout_in = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ticks_ff <= PHASE_TICKS_RESET;
         ack_timeout_ff <= ACK_TIMEOUT_RESET;
      end else begin
         phase_ticks_ff <= phase_ticks_in;
         ack_timeout_ff <= ack_timeout_in;
      end
   end

   assign cfg.phase_ticks = phase_ticks_ff;
   assign cfg.ack_timeout = ack_timeout_ff;

endmodule

// ===== hw/rtl/i2crm_seq.sv =====
module i2crm_seq (
   input  logic                clock,
   input  logic                reset,
   input  logic                step_en,
   input  i2crm_pkg::req_type  item,
   input  i2crm_pkg::cfg_type  cfg,
   output i2crm_pkg::rsp_type  result
);
   import i2crm_pkg::*;

   typedef enum logic [18:0] {
      ST_IDLE  = 19'h00001,
      ST_SHI   = 19'h00002,
      ST_SCHK  = 19'h00004,
      ST_SLOW  = 19'h00008,
      ST_SDN   = 19'h00010,
      ST_TXLO  = 19'h00020,
      ST_TXHI  = 19'h00040,
      ST_APREP = 19'h00080,
      ST_APOLL = 19'h00100,
      ST_AEND  = 19'h00200,
      ST_WAIT  = 19'h00400,
      ST_RXLO  = 19'h00800,
      ST_RXHI  = 19'h01000,
      ST_KLO   = 19'h02000,
      ST_KHI   = 19'h04000,
      ST_KEND  = 19'h08000,
      ST_PLO   = 19'h10000,
      ST_PHI   = 19'h20000,
      ST_PEND  = 19'h40000
   } state_type;

   // Which byte of the transaction is on the bus.
   typedef enum logic [1:0] {
      STG_ADDRW = 2'd0,
      STG_REG   = 2'd1,
      STG_DATA  = 2'd2,
      STG_ADDRR = 2'd3
   } stage_type;

   state_type  state_ff, state_in;
   stage_type  stage_ff, stage_in;
   logic [7:0] phase_count_ff, phase_count_in;
   logic [3:0] bit_index_ff, bit_index_in;
   logic [7:0] shift_byte_ff, shift_byte_in;
   logic [7:0] bytes_left_ff, bytes_left_in;
   logic [6:0] held_device_ff, held_device_in;
   logic [7:0] held_register_ff, held_register_in;
   logic       held_direction_ff, held_direction_in;
   logic [7:0] ack_wait_ff, ack_wait_in;
   logic [1:0] result_code_ff, result_code_in;

   always_comb begin
      logic       hold;
      logic [7:0] phase_step;
      logic       txbit;
      logic       nack;
      logic [3:0] bit_inc;
      logic [7:0] left_dec;
      logic [7:0] rx_byte;

      hold       = (phase_count_ff >= cfg.phase_ticks);
      phase_step = hold ? 8'd0 : phase_count_ff + 8'd1;
      txbit      = shift_byte_ff[7];
      nack       = (bytes_left_ff <= 8'd1);
      bit_inc    = bit_index_ff + 4'd1;
      left_dec   = (bytes_left_ff != 8'd0) ? bytes_left_ff - 8'd1 : bytes_left_ff;
      rx_byte    = {shift_byte_ff[6:0], item.sda_in};

      state_in          = state_ff;
      stage_in          = stage_ff;
      phase_count_in    = phase_count_ff;
      bit_index_in      = bit_index_ff;
      shift_byte_in     = shift_byte_ff;
      bytes_left_in     = bytes_left_ff;
      held_device_in    = held_device_ff;
      held_register_in  = held_register_ff;
      held_direction_in = held_direction_ff;
      ack_wait_in       = ack_wait_ff;
      result_code_in    = result_code_ff;

      result          = '0;
      result.scl_out  = 1'b1;
      result.sda_out  = 1'b1;
      result.busy_res = (state_ff != ST_IDLE);

      unique case (state_ff)
         ST_IDLE: begin
            if (item.cmd_valid) begin
               held_device_in    = item.dev_addr;
               held_register_in  = item.reg_addr;
               held_direction_in = item.cmd_read;
               bytes_left_in     = item.byte_count;
               result_code_in    = STATUS_OK;
               stage_in          = STG_ADDRW;
               phase_count_in    = 8'd0;
               state_in          = ST_SHI;
            end
         end
         ST_SHI: begin
            result.sda_oe  = 1'b1;
            phase_count_in = phase_step;
            if (hold) state_in = ST_SCHK;
         end
         ST_SCHK: begin
            // Only the first START checks that the bus is free.
            if (stage_ff == STG_ADDRW && !item.sda_in) begin
               result_code_in  = STATUS_BUS_BUSY;
               result.done_res = 1'b1;
               result.status   = STATUS_BUS_BUSY;
               state_in        = ST_IDLE;
            end else begin
               state_in = ST_SLOW;
            end
         end
         ST_SLOW: begin
            result.sda_out = 1'b0;
            result.sda_oe  = 1'b1;
            phase_count_in = phase_step;
            if (hold) state_in = ST_SDN;
         end
         ST_SDN: begin
            result.scl_out = 1'b0;
            result.sda_out = 1'b0;
            result.sda_oe  = 1'b1;
            phase_count_in = phase_step;
            if (hold) begin
               shift_byte_in = {held_device_ff, stage_ff == STG_ADDRR};
               bit_index_in  = 4'd0;
               state_in      = ST_TXLO;
            end
         end
         ST_TXLO: begin
            result.scl_out = 1'b0;
            result.sda_out = txbit;
            result.sda_oe  = 1'b1;
            phase_count_in = phase_step;
            if (hold) state_in = ST_TXHI;
         end
         ST_TXHI: begin
            result.sda_out = txbit;
            result.sda_oe  = 1'b1;
            phase_count_in = phase_step;
            if (hold) begin
               shift_byte_in = {shift_byte_ff[6:0], 1'b0};
               bit_index_in  = bit_inc;
               state_in      = (bit_inc >= 4'd8) ? ST_APREP : ST_TXLO;
            end
         end
         ST_APREP: begin
            result.scl_out = 1'b0;
            result.sda_oe  = 1'b1;
            phase_count_in = phase_step;
            if (hold) begin
               ack_wait_in = 8'd0;
               state_in    = ST_APOLL;
            end
         end
         ST_APOLL: begin
            if (!item.sda_in) begin
               state_in = ST_AEND;
            end else if (ack_wait_ff >= cfg.ack_timeout) begin
               // Only the device address byte aborts on a missing ACK.
               if (stage_ff == STG_ADDRW) begin
                  result_code_in = STATUS_NO_ACK;
                  state_in       = ST_PLO;
               end else begin
                  state_in = ST_AEND;
               end
            end else begin
               ack_wait_in = ack_wait_ff + 8'd1;
            end
         end
         ST_AEND: begin
            result.scl_out = 1'b0;
            phase_count_in = phase_step;
            if (hold) begin
               unique case (stage_ff)
                  STG_ADDRW: begin
                     stage_in      = STG_REG;
                     shift_byte_in = held_register_ff;
                     bit_index_in  = 4'd0;
                     state_in      = ST_TXLO;
                  end
                  STG_REG: begin
                     if (held_direction_ff) begin
                        stage_in = STG_ADDRR;
                        state_in = ST_SHI;
                     end else begin
                        stage_in = STG_DATA;
                        state_in = (bytes_left_ff == 8'd0) ? ST_PLO : ST_WAIT;
                     end
                  end
                  STG_DATA: begin
                     bytes_left_in = left_dec;
                     state_in      = (left_dec == 8'd0) ? ST_PLO : ST_WAIT;
                  end
                  STG_ADDRR: begin
                     shift_byte_in = 8'd0;
                     bit_index_in  = 4'd0;
                     state_in      = (bytes_left_ff == 8'd0) ? ST_PLO : ST_RXLO;
                  end
                  default: ;
               endcase
            end
         end
         ST_WAIT: begin
            result.scl_out         = 1'b0;
            result.wr_data_request = 1'b1;
            if (item.wr_data_valid) begin
               phase_count_in = 8'd0;
               shift_byte_in  = item.wr_data;
               bit_index_in   = 4'd0;
               state_in       = ST_TXLO;
            end
         end
         ST_RXLO: begin
            result.scl_out = 1'b0;
            phase_count_in = phase_step;
            if (hold) state_in = ST_RXHI;
         end
         ST_RXHI: begin
            phase_count_in = phase_step;
            if (hold) begin
               shift_byte_in = rx_byte;
               bit_index_in  = bit_inc;
               if (bit_inc >= 4'd8) begin
                  result.rd_valid = 1'b1;
                  result.rd_data  = rx_byte;
                  result.rd_last  = nack;
                  state_in        = ST_KLO;
               end else begin
                  state_in = ST_RXLO;
               end
            end
         end
         ST_KLO: begin
            result.scl_out = 1'b0;
            result.sda_out = nack;
            result.sda_oe  = 1'b1;
            phase_count_in = phase_step;
            if (hold) state_in = ST_KHI;
         end
         ST_KHI: begin
            result.sda_out = nack;
            result.sda_oe  = 1'b1;
            phase_count_in = phase_step;
            if (hold) state_in = ST_KEND;
         end
         ST_KEND: begin
            result.scl_out = 1'b0;
            result.sda_out = nack;
            result.sda_oe  = 1'b1;
            phase_count_in = phase_step;
            if (hold) begin
               bytes_left_in = left_dec;
               shift_byte_in = 8'd0;
               bit_index_in  = 4'd0;
               state_in      = (left_dec == 8'd0) ? ST_PLO : ST_RXLO;
            end
         end
         ST_PLO: begin
            result.scl_out = 1'b0;
            result.sda_out = 1'b0;
            result.sda_oe  = 1'b1;
            phase_count_in = phase_step;
            if (hold) state_in = ST_PHI;
         end
         ST_PHI: begin
            result.sda_out = 1'b0;
            result.sda_oe  = 1'b1;
            phase_count_in = phase_step;
            if (hold) state_in = ST_PEND;
         end
         ST_PEND: begin
            result.sda_oe  = 1'b1;
            phase_count_in = phase_step;
            if (hold) begin
               result.done_res = 1'b1;
               result.status   = result_code_ff;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= ST_IDLE;
         stage_ff          <= STG_ADDRW;
         phase_count_ff    <= 8'd0;
         bit_index_ff      <= 4'd0;
         shift_byte_ff     <= 8'd0;
         bytes_left_ff     <= 8'd0;
         held_device_ff    <= 7'd0;
         held_register_ff  <= 8'd0;
         held_direction_ff <= 1'b0;
         ack_wait_ff       <= 8'd0;
         result_code_ff    <= STATUS_OK;
      end else if (step_en) begin
         state_ff          <= state_in;
         stage_ff          <= stage_in;
         phase_count_ff    <= phase_count_in;
         bit_index_ff      <= bit_index_in;
         shift_byte_ff     <= shift_byte_in;
         bytes_left_ff     <= bytes_left_in;
         held_device_ff    <= held_device_in;
         held_register_ff  <= held_register_in;
         held_direction_ff <= held_direction_in;
         ack_wait_ff       <= ack_wait_in;
         result_code_ff    <= result_code_in;
      end
   end

   // A failed START check never reaches the bus with a STOP.
   a_busy_fail_idle: assert property (@(posedge clock) disable iff (reset)
      (step_en && result.done_res && result.status == STATUS_BUS_BUSY) |=> state_ff == ST_IDLE)
      else $error("bus-busy completion did not return to idle");

   a_no_ack_only_addr: assert property (@(posedge clock) disable iff (reset)
      (step_en && state_ff == ST_APOLL && result_code_in == STATUS_NO_ACK
       && result_code_ff != STATUS_NO_ACK) |-> stage_ff == STG_ADDRW)
      else $error("address timeout flagged outside the device address byte");

   a_rx_only_read: assert property (@(posedge clock) disable iff (reset)
      (step_en && result.rd_valid) |-> held_direction_ff && stage_ff == STG_ADDRR)
      else $error("received byte outside a read transaction");

   a_bit_index_range: assert property (@(posedge clock) disable iff (reset)
      bit_index_ff <= 4'd8)
      else $error("bit index out of range");

endmodule

// ===== hw/rtl/i2c_register_master.sv =====
// I2C register master. Each accepted request is one bus tick: it carries the
// sampled SDA level and, while the block is idle, an optional read or write
// command; each tick produces exactly one response with the SCL/SDA drive and
// the tick's events (received byte, write-data request, completion status).
// One tick is accepted every clock cycle unless the response path stalls, and its
// response appears after the request register and the response register; the bus
// sequencer advances one state step for each tick it takes. Each bus
// phase lasts 1 + phase_ticks ticks, and ACK is polled for up to
// ack_timeout + 1 ticks. Configuration writes are accepted at any time and
// should be made while no transaction is in progress.
module i2c_register_master (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  i2crm_pkg::req_type                   req_item,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output i2crm_pkg::rsp_type                   rsp_item,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [i2crm_pkg::CsrIndexWidth-1:0]  csr_index,
   input  logic [i2crm_pkg::CsrDataWidth-1:0]   csr_data
);
   import i2crm_pkg::*;

   cfg_type cfg;
   req_type s1_item_ff;
   logic    s1_valid_ff, s1_valid_in;
   rsp_type rsp_item_ff;
   rsp_type step_result;
   logic    rsp_valid_ff, rsp_valid_in;
   logic    out_free;
   logic    step_en;
   logic    req_accept;

   i2crm_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   i2crm_seq u_seq (
      .clock   (clock),
      .reset   (reset),
      .step_en (step_en),
      .item    (s1_item_ff),
      .cfg     (cfg),
      .result  (step_result)
   );

   // The sequencer steps when the response register can take the result.
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign step_en    = s1_valid_ff && out_free;
   assign req_stall  = s1_valid_ff && !out_free;
   assign req_accept = req_valid && !req_stall;

   assign s1_valid_in  = req_accept || (s1_valid_ff && !step_en);
   assign rsp_valid_in = step_en || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) s1_item_ff <= req_item;
      if (step_en) rsp_item_ff <= step_result;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   a_stall_needs_item: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> s1_valid_ff && rsp_valid_ff)
      else $error("request stalled with a free pipeline");

   a_step_fills_rsp: assert property (@(posedge clock) disable iff (reset)
      step_en |=> rsp_valid_ff)
      else $error("sequencer step lost its response");

   a_blocked_item_kept: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !step_en) |=> s1_valid_ff && $stable(s1_item_ff))
      else $error("waiting request was dropped or changed");

endmodule

// ===== sim/i2crm_checker.sv =====
module i2crm_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_stall,
   input  i2crm_pkg::req_type                  req_item,
   input  logic                                rsp_valid,
   input  logic                                rsp_stall,
   input  i2crm_pkg::rsp_type                  rsp_item,
   input  logic                                csr_valid,
   input  logic                                csr_ready,
   input  logic [i2crm_pkg::CsrIndexWidth-1:0] csr_index,
   input  logic [i2crm_pkg::CsrDataWidth-1:0]  csr_data,
   input  logic                                drain_done,
   output int                                  fail_count
);
   timeunit 1ns;
   timeprecision 1ps;
   import i2crm_pkg::*;

   typedef enum logic [4:0] {
      S_IDLE, S_START_HI, S_START_CHK, S_START_LO, S_START_DN,
      S_TX_LO, S_TX_HI, S_ACK_PREP, S_ACK_POLL, S_ACK_END,
      S_WR_WAIT, S_RX_LO, S_RX_HI, S_MACK_LO, S_MACK_HI, S_MACK_END,
      S_STOP_LO, S_STOP_HI, S_STOP_END
   } bus_state_type;

   typedef enum logic [1:0] {
      STAGE_ADDR_WR, STAGE_REG, STAGE_DATA, STAGE_ADDR_RD
   } byte_stage_type;

   cfg_type        cfg;
   bus_state_type  seq;
   byte_stage_type stage;
   logic [7:0]     phase_cnt;
   logic [3:0]     bit_idx;
   logic [7:0]     shift_reg;
   logic [7:0]     bytes_left;
   logic [6:0]     dev_hold;
   logic [7:0]     addr_hold;
   logic           read_hold;
   logic [7:0]     ack_wait;
   logic [1:0]     result;

   rsp_type     bus_expect_q[$];
   int          rsp_index;
   bit          leftover_checked;

   task automatic report(input string msg);
      if (fail_count < 40)
         $display("ERROR at %0t: %s", $time, msg);
      fail_count++;
   endtask

   task automatic check_field(input string name, input logic [7:0] got,
                              input logic [7:0] want);
      if (got !== want)
         report($sformatf("response %0d field %s is %0h, expected %0h",
                          rsp_index, name, got, want));
   endtask

   function automatic bit phase_done();
      if (phase_cnt >= cfg.phase_ticks) begin
         phase_cnt = '0;
         return 1'b1;
      end
      phase_cnt++;
      return 1'b0;
   endfunction

   function automatic void load_tx(input logic [7:0] value);
      shift_reg = value;
      bit_idx   = '0;
      seq       = S_TX_LO;
   endfunction

   // Advances the bus sequencer by one tick and returns what the block drives.
   function automatic rsp_type step_bus(input req_type t);
      rsp_type r;
      logic    tx_bit;
      logic    nack_bit;
      r         = '0;
      r.scl_out = 1'b1;
      r.sda_out = 1'b1;
      tx_bit    = shift_reg[7];
      nack_bit  = (bytes_left <= 8'd1);
      r.busy_res = (seq != S_IDLE);

      // Line levels come from the state held at the start of the tick.
      case (seq)
         S_START_HI: begin r.sda_out = 1'b1; r.sda_oe = 1'b1; end
         S_START_LO: begin r.sda_out = 1'b0; r.sda_oe = 1'b1; end
         S_START_DN: begin r.scl_out = 1'b0; r.sda_out = 1'b0; r.sda_oe = 1'b1; end
         S_TX_LO: begin r.scl_out = 1'b0; r.sda_out = tx_bit; r.sda_oe = 1'b1; end
         S_TX_HI: begin r.sda_out = tx_bit; r.sda_oe = 1'b1; end
         S_ACK_PREP: begin r.scl_out = 1'b0; r.sda_out = 1'b1; r.sda_oe = 1'b1; end
         S_ACK_END, S_WR_WAIT, S_RX_LO: r.scl_out = 1'b0;
         S_MACK_LO, S_MACK_END: begin
            r.scl_out = 1'b0; r.sda_out = nack_bit; r.sda_oe = 1'b1;
         end
         S_MACK_HI: begin r.sda_out = nack_bit; r.sda_oe = 1'b1; end
         S_STOP_LO: begin r.scl_out = 1'b0; r.sda_out = 1'b0; r.sda_oe = 1'b1; end
         S_STOP_HI: begin r.sda_out = 1'b0; r.sda_oe = 1'b1; end
         S_STOP_END: begin r.sda_out = 1'b1; r.sda_oe = 1'b1; end
         default: ;
      endcase

      case (seq)
         S_IDLE: begin
            if (t.cmd_valid) begin
               dev_hold   = t.dev_addr;
               addr_hold  = t.reg_addr;
               read_hold  = t.cmd_read;
               bytes_left = t.byte_count;
               result     = STATUS_OK;
               stage      = STAGE_ADDR_WR;
               phase_cnt  = '0;
               seq        = S_START_HI;
            end
         end
         S_START_HI: if (phase_done()) seq = S_START_CHK;
         S_START_CHK: begin
            // Only the first START checks that the bus is free.
            if (stage == STAGE_ADDR_WR && !t.sda_in) begin
               result     = STATUS_BUS_BUSY;
               r.done_res = 1'b1;
               r.status   = STATUS_BUS_BUSY;
               seq        = S_IDLE;
            end else begin
               seq = S_START_LO;
            end
         end
         S_START_LO: if (phase_done()) seq = S_START_DN;
         S_START_DN: if (phase_done()) load_tx({dev_hold, stage == STAGE_ADDR_RD});
         S_TX_LO: if (phase_done()) seq = S_TX_HI;
         S_TX_HI: begin
            if (phase_done()) begin
               shift_reg = shift_reg << 1;
               bit_idx++;
               seq = (bit_idx >= 4'd8) ? S_ACK_PREP : S_TX_LO;
            end
         end
         S_ACK_PREP: begin
            if (phase_done()) begin
               ack_wait = '0;
               seq      = S_ACK_POLL;
            end
         end
         S_ACK_POLL: begin
            if (!t.sda_in) begin
               seq = S_ACK_END;
            end else if (ack_wait >= cfg.ack_timeout) begin
               // Only a missing acknowledge of the write address byte aborts the transaction.
               if (stage == STAGE_ADDR_WR) begin
                  result = STATUS_NO_ACK;
                  seq    = S_STOP_LO;
               end else begin
                  seq = S_ACK_END;
               end
            end else begin
               ack_wait++;
            end
         end
         S_ACK_END: begin
            if (phase_done()) begin
               case (stage)
                  STAGE_ADDR_WR: begin
                     stage = STAGE_REG;
                     load_tx(addr_hold);
                  end
                  STAGE_REG: begin
                     if (read_hold) begin
                        stage = STAGE_ADDR_RD;
                        seq   = S_START_HI;
                     end else begin
                        stage = STAGE_DATA;
                        seq   = (bytes_left == 8'd0) ? S_STOP_LO : S_WR_WAIT;
                     end
                  end
                  STAGE_DATA: begin
                     if (bytes_left > 8'd0) bytes_left--;
                     seq = (bytes_left == 8'd0) ? S_STOP_LO : S_WR_WAIT;
                  end
                  default: begin
                     shift_reg = '0;
                     bit_idx   = '0;
                     seq       = (bytes_left == 8'd0) ? S_STOP_LO : S_RX_LO;
                  end
               endcase
            end
         end
         S_WR_WAIT: begin
            r.wr_data_request = 1'b1;
            if (t.wr_data_valid) begin
               phase_cnt = '0;
               load_tx(t.wr_data);
            end
         end
         S_RX_LO: if (phase_done()) seq = S_RX_HI;
         S_RX_HI: begin
            if (phase_done()) begin
               shift_reg = {shift_reg[6:0], t.sda_in};
               bit_idx++;
               if (bit_idx >= 4'd8) begin
                  r.rd_valid = 1'b1;
                  r.rd_data  = shift_reg;
                  r.rd_last  = (bytes_left <= 8'd1);
                  seq        = S_MACK_LO;
               end else begin
                  seq = S_RX_LO;
               end
            end
         end
         S_MACK_LO: if (phase_done()) seq = S_MACK_HI;
         S_MACK_HI: if (phase_done()) seq = S_MACK_END;
         S_MACK_END: begin
            if (phase_done()) begin
               if (bytes_left > 8'd0) bytes_left--;
               shift_reg = '0;
               bit_idx   = '0;
               seq       = (bytes_left == 8'd0) ? S_STOP_LO : S_RX_LO;
            end
         end
         S_STOP_LO: if (phase_done()) seq = S_STOP_HI;
         S_STOP_HI: if (phase_done()) seq = S_STOP_END;
         S_STOP_END: begin
            if (phase_done()) begin
               r.done_res = 1'b1;
               r.status   = result;
               seq        = S_IDLE;
            end
         end
         default: seq = S_IDLE;
      endcase

      if (!r.sda_oe) r.sda_out = 1'b1;
      return r;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         cfg.phase_ticks = PHASE_TICKS_RESET;
         cfg.ack_timeout = ACK_TIMEOUT_RESET;
         seq        = S_IDLE;
         stage      = STAGE_ADDR_WR;
         phase_cnt  = '0;
         bit_idx    = '0;
         shift_reg  = '0;
         bytes_left = '0;
         dev_hold   = '0;
         addr_hold  = '0;
         read_hold  = 1'b0;
         ack_wait   = '0;
         result     = STATUS_OK;
         bus_expect_q.delete();
         rsp_index  = 0;
         fail_count = 0;
         leftover_checked = 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_PHASE_TICKS: cfg.phase_ticks = csr_data;
               CSR_ACK_TIMEOUT: cfg.ack_timeout = csr_data;
               default: ;
            endcase
         end
         if (req_valid && !req_stall)
            bus_expect_q.push_back(step_bus(req_item));
         if (rsp_valid && !rsp_stall) begin
            if (bus_expect_q.size() == 0) begin
               report($sformatf("response %0d arrived with no tick pending", rsp_index));
            end else begin
               want = bus_expect_q.pop_front();
               check_field("scl_out", 8'(rsp_item.scl_out), 8'(want.scl_out));
               check_field("sda_out", 8'(rsp_item.sda_out), 8'(want.sda_out));
               check_field("sda_oe", 8'(rsp_item.sda_oe), 8'(want.sda_oe));
               check_field("rd_data", rsp_item.rd_data, want.rd_data);
               check_field("rd_valid", 8'(rsp_item.rd_valid), 8'(want.rd_valid));
               check_field("rd_last", 8'(rsp_item.rd_last), 8'(want.rd_last));
               check_field("wr_data_request", 8'(rsp_item.wr_data_request),
                           8'(want.wr_data_request));
               check_field("busy_res", 8'(rsp_item.busy_res), 8'(want.busy_res));
               check_field("done_res", 8'(rsp_item.done_res), 8'(want.done_res));
               check_field("status", 8'(rsp_item.status), 8'(want.status));
            end
            rsp_index++;
         end
         if (drain_done && !leftover_checked) begin
            leftover_checked = 1'b1;
            if (bus_expect_q.size() != 0)
               report($sformatf("%0d ticks never got a response", bus_expect_q.size()));
         end
      end
   end

endmodule

// ===== sim/tb_top.sv =====
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import i2crm_pkg::*;

   localparam int CycleLimit = 500_000;

   typedef enum int {
      SDA_LOW, SDA_HIGH, SDA_HIGH_THEN_LOW, SDA_HIGH_THEN_RANDOM, SDA_RANDOM
   } sda_mode_type;

   logic                     clock;
   logic                     reset;
   logic                     req_valid;
   logic                     req_stall;
   req_type                  req_item;
   logic                     rsp_valid;
   logic                     rsp_stall;
   rsp_type                  rsp_item;
   logic                     csr_valid;
   logic                     csr_ready;
   logic [CsrIndexWidth-1:0] csr_index;
   logic [CsrDataWidth-1:0]  csr_data;
   logic                     drain_done;
   int                       fail_count;

   int           req_sent;
   int           rsp_seen;
   logic         last_busy;
   int           ticks_since_cmd;
   int           cur_phase_ticks;
   int           sda_low_pct;
   sda_mode_type sda_mode;
   bit           calm;
   bit           press_req;
   int           cycle_count;

   i2c_register_master dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   i2crm_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_item   (req_item),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_item   (rsp_item),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .drain_done (drain_done),
      .fail_count (fail_count)
   );

   initial clock = 1'b0;
   always #2 clock = ~clock;

   always @(posedge clock) begin
      if (reset) begin
         rsp_seen  <= 0;
         last_busy <= 1'b0;
      end else if (rsp_valid && !rsp_stall) begin
         rsp_seen  <= rsp_seen + 1;
         last_busy <= rsp_item.busy_res;
      end
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 10);
      return $urandom_range(15, 50);
   endfunction

   // Builds one bus tick; the slave side of the bus is modeled only through sda_in.
   function automatic req_type make_tick(input bit with_cmd);
      req_type t;
      t.cmd_valid     = with_cmd;
      t.cmd_read      = 1'($urandom_range(0, 1));
      t.dev_addr      = 7'($urandom_range(0, 127));
      t.reg_addr      = 8'($urandom_range(0, 255));
      t.byte_count    = 8'($urandom_range(0, 255));
      t.wr_data       = 8'($urandom_range(0, 255));
      t.wr_data_valid = ($urandom_range(0, 3) != 0);
      case (sda_mode)
         SDA_LOW:  t.sda_in = 1'b0;
         SDA_HIGH: t.sda_in = 1'b1;
         SDA_HIGH_THEN_LOW:
            t.sda_in = (ticks_since_cmd < cur_phase_ticks + 3);
         SDA_HIGH_THEN_RANDOM:
            t.sda_in = (ticks_since_cmd < cur_phase_ticks + 3) ? 1'b1
                                                               : 1'($urandom_range(0, 1));
         default: t.sda_in = ($urandom_range(0, 99) >= sda_low_pct);
      endcase
      return t;
   endfunction

   // Entered and left at a falling edge.
   task automatic send_tick(input req_type t);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_item  <= t;
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      req_sent++;
      ticks_since_cmd++;
      @(negedge clock);
   endtask

   task automatic write_csr(input logic [CsrIndexWidth-1:0] idx,
                            input logic [CsrDataWidth-1:0] value);
      csr_index <= idx;
      csr_data  <= value;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
      if (idx == CSR_PHASE_TICKS) cur_phase_ticks = int'(value);
   endtask

   // Idle ticks until every response is back and the sequencer reports idle.
   task automatic settle();
      req_type t;
      int      i;
      bit      idle;
      idle = 1'b0;
      while (!idle) begin
         for (i = 0; i < 16; i++) begin
            t = make_tick(1'b0);
            send_tick(t);
         end
         req_valid <= 1'b0;
         @(negedge clock);
         while (rsp_seen != req_sent) @(negedge clock);
         idle = !last_busy;
      end
   endtask

   task automatic run_command(input logic rd, input logic [6:0] dev,
                              input logic [7:0] ra, input logic [7:0] cnt,
                              input sda_mode_type mode);
      req_type t;
      sda_mode        = mode;
      ticks_since_cmd = 0;
      t               = make_tick(1'b1);
      t.cmd_read      = rd;
      t.dev_addr      = dev;
      t.reg_addr      = ra;
      t.byte_count    = cnt;
      send_tick(t);
      settle();
   endtask

   // Commands arrive at random, so many land while a transaction is running.
   task automatic run_random(input int n_ticks, input int max_count, input int low_pct);
      req_type t;
      int      i;
      sda_mode    = SDA_RANDOM;
      sda_low_pct = low_pct;
      for (i = 0; i < n_ticks; i++) begin
         if (i % 64 == 0) calm = ($urandom_range(0, 3) == 0);
         t = make_tick($urandom_range(0, 7) == 0);
         if (t.cmd_valid) t.byte_count = 8'($urandom_range(0, max_count));
         send_tick(t);
      end
      calm = 1'b0;
      settle();
   endtask

   initial begin
      int run_left;
      bit stall_val;
      rsp_stall = 1'b0;
      run_left  = 0;
      stall_val = 1'b0;
      forever begin
         @(negedge clock);
         if (press_req) begin
            // Long hold-off so the response path backs up into the request side.
            rsp_stall <= 1'b1;
            repeat (300) @(negedge clock);
            press_req = 1'b0;
            rsp_stall <= 1'b0;
         end else if (calm) begin
            rsp_stall <= 1'b0;
         end else begin
            if (run_left == 0) begin
               run_left = $urandom_range(0, 99);
               if (run_left < 65) begin
                  stall_val = 1'b0;
                  run_left  = $urandom_range(1, 16);
               end else if (run_left < 92) begin
                  stall_val = 1'b1;
                  run_left  = $urandom_range(1, 3);
               end else begin
                  stall_val = 1'b1;
                  run_left  = $urandom_range(8, 40);
               end
            end
            rsp_stall <= stall_val;
            run_left--;
         end
      end
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CycleLimit) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("tb_top failed");
      $finish;
   end

   initial begin
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_item        = '0;
      csr_valid       = 1'b0;
      csr_index       = '0;
      csr_data        = '0;
      drain_done      = 1'b0;
      req_sent        = 0;
      ticks_since_cmd = 0;
      cur_phase_ticks = PHASE_TICKS_RESET;
      sda_low_pct     = 50;
      sda_mode        = SDA_RANDOM;
      calm            = 1'b0;
      press_req       = 1'b0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed transactions at the reset settings.
      run_command(1'b0, 7'h7F, 8'hFF, 8'd1, SDA_HIGH_THEN_LOW);
      run_command(1'b0, 7'h55, 8'hAA, 8'd1, SDA_LOW);
      run_command(1'b1, 7'h2A, 8'h55, 8'd1, SDA_HIGH);

      // Short transfers at the fastest phase setting.
      write_csr(CSR_PHASE_TICKS, 8'd0);
      write_csr(CSR_ACK_TIMEOUT, 8'd255);
      run_command(1'b1, 7'h00, 8'h00, 8'd3, SDA_HIGH_THEN_RANDOM);
      run_command(1'b0, 7'($urandom_range(0, 127)), 8'($urandom_range(0, 255)), 8'd0,
                  SDA_HIGH_THEN_LOW);

      write_csr(CSR_ACK_TIMEOUT, 8'd0);
      press_req = 1'b1;
      run_random(48, 3, 50);

      write_csr(CSR_PHASE_TICKS, 8'd1);
      write_csr(CSR_ACK_TIMEOUT, 8'd3);
      run_random(48, 3, 40);

      write_csr(CSR_PHASE_TICKS, 8'($urandom_range(0, 2)));
      write_csr(CSR_ACK_TIMEOUT, 8'($urandom_range(0, 255)));
      run_random(48, 4, 50);

      // Slowest phase setting: a START that finds the bus held low.
      write_csr(CSR_PHASE_TICKS, 8'd255);
      write_csr(CSR_ACK_TIMEOUT, 8'd255);
      calm = 1'b1;
      run_command(1'b1, 7'($urandom_range(0, 127)), 8'($urandom_range(0, 255)), 8'd1,
                  SDA_LOW);
      calm = 1'b0;

      req_valid <= 1'b0;
      repeat (8) @(negedge clock);
      drain_done <= 1'b1;
      repeat (2) @(negedge clock);
      if (fail_count == 0)
         $display("tb_top passed");
      else
         $display("tb_top failed");
      $finish;
   end

endmodule
